/* hw/rtl/lesf_pkg.sv */
// Shared constants, types and helpers for the largest empty square finder.
// No dependencies; every other file but lesf_ram refers to it by scoped names.
package lesf_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CFG_W      = 11;  // num_columns / num_lines register width
    localparam int SIZE_OUT_W = 11;  // m_square_size width
    localparam int POS_OUT_W  = 10;  // m_corner_row / m_corner_col width
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_COLUMNS = 1'b0;
    localparam logic REG_NUM_LINES   = 1'b1;

    typedef struct packed {
        logic             restart;
        logic [CFG_W-1:0] num_columns;
        logic [CFG_W-1:0] num_lines;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic cell_empty;
        logic first_row;
        logic first_col;
        logic last_col;
        logic last_row;
    } cell_ctl_t;

    // zero reads as one, anything past the limit saturates
    function automatic logic [CFG_W-1:0] clamp_count(logic [CFG_W-1:0] v, int unsigned maxv);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (32'(v) > maxv) begin
            r = CFG_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/largest_empty_square_finder_core.sv */
// The result of a grid is registered once its last cell leaves the input register stage.
// Throughput: 1 cell per cycle unless a last cell waits for the prior result to be taken;
// the line-buffer read, issued as a cell is taken, serves it in stage 1 beside the size write.
// Reset (aresetn low, synchronous): scan position, best square and handshakes clear,
// registers return to 1024 clamped to MAX_COLS/MAX_ROWS; line buffer is not cleared.
// Depends on lesf_pkg, lesf_cfg, lesf_scan, lesf_core and lesf_ram.
module largest_empty_square_finder_core #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lesf_pkg::APB_AW-1:0]     paddr,
    input  logic [lesf_pkg::APB_DW-1:0]     pwdata,
    output logic [lesf_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cell_empty,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [lesf_pkg::SIZE_OUT_W-1:0] m_square_size,
    output logic [lesf_pkg::POS_OUT_W-1:0]  m_corner_row,
    output logic [lesf_pkg::POS_OUT_W-1:0]  m_corner_col
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SW = $clog2(MAX_COLS + 1);

    lesf_pkg::cfg_t      cfg;
    lesf_pkg::cell_ctl_t s1_ctl;
    logic [CW-1:0]       s1_col;
    logic [RW-1:0]       s1_row;
    logic                s1_adv;
    logic                ram_re, ram_we;
    logic [CW-1:0]       ram_raddr, ram_waddr;
    logic [SW-1:0]       ram_rdata, ram_wdata;

    lesf_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lesf_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_empty (s_cell_empty),
        .s1_adv       (s1_adv),
        .s1_ctl       (s1_ctl),
        .s1_col       (s1_col),
        .s1_row       (s1_row),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr)
    );

    lesf_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_COLS)
    ) u_line_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lesf_core #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s1_ctl        (s1_ctl),
        .s1_col        (s1_col),
        .s1_row        (s1_row),
        .s1_adv        (s1_adv),
        .ram_rdata     (ram_rdata),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_square_size (m_square_size),
        .m_corner_row  (m_corner_row),
        .m_corner_col  (m_corner_col)
    );

endmodule

/* hw/rtl/lesf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone; used as the line buffer of the previous row's sizes.
module lesf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/lesf_cfg.sv */
// APB-style register block for num_columns and num_lines.
// Depends on lesf_pkg for widths, register indexes and the clamp helper.
module lesf_cfg #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lesf_pkg::APB_AW-1:0]  paddr,
    input  logic [lesf_pkg::APB_DW-1:0]  pwdata,
    output logic [lesf_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output lesf_pkg::cfg_t               cfg
);

    logic [lesf_pkg::CFG_W-1:0] ncols_reg;
    logic [lesf_pkg::CFG_W-1:0] nlines_reg;
    logic                       wr;
    logic [lesf_pkg::CFG_W-1:0] wval;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign wval   = pwdata[lesf_pkg::CFG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncols_reg  <= lesf_pkg::clamp_count(lesf_pkg::CFG_RESET, MAX_COLS);
            nlines_reg <= lesf_pkg::clamp_count(lesf_pkg::CFG_RESET, MAX_ROWS);
        end else if (wr) begin
            case (paddr[2])
                lesf_pkg::REG_NUM_COLUMNS: ncols_reg  <= lesf_pkg::clamp_count(wval, MAX_COLS);
                lesf_pkg::REG_NUM_LINES:   nlines_reg <= lesf_pkg::clamp_count(wval, MAX_ROWS);
                default:                   nlines_reg <= nlines_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            lesf_pkg::REG_NUM_COLUMNS: prdata = lesf_pkg::APB_DW'(ncols_reg);
            default:                   prdata = lesf_pkg::APB_DW'(nlines_reg);
        endcase
    end

    // any write restarts the scan
    assign cfg.restart     = wr;
    assign cfg.num_columns = ncols_reg;
    assign cfg.num_lines   = nlines_reg;

endmodule

/* hw/rtl/lesf_scan.sv */
// Scan position counters and input register stage; issues the line-buffer read.
// Depends on lesf_pkg for the config and cell control structs.
module lesf_scan #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  lesf_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cell_empty,
    input  logic                s1_adv,
    output lesf_pkg::cell_ctl_t s1_ctl,
    output logic [CW-1:0]       s1_col,
    output logic [RW-1:0]       s1_row,
    output logic                ram_re,
    output logic [CW-1:0]       ram_raddr
);

    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                s1_valid_reg;
    lesf_pkg::cell_ctl_t s1_ctl_reg;
    logic [CW-1:0]       s1_col_reg;
    logic [RW-1:0]       s1_row_reg;
    logic                accept;
    logic                last_col;
    logic                last_row;

    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    assign last_col = (32'(col_reg) + 32'd1) >= 32'(cfg.num_columns);
    assign last_row = (32'(row_reg) + 32'd1) >= 32'(cfg.num_lines);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + RW'(1);
        end else begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (cfg.restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_valid_reg <= accept || (s1_valid_reg && !s1_adv);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg.valid      <= 1'b1;
            s1_ctl_reg.cell_empty <= s_cell_empty;
            s1_ctl_reg.first_row  <= (row_reg == '0);
            s1_ctl_reg.first_col  <= (col_reg == '0);
            s1_ctl_reg.last_col   <= last_col;
            s1_ctl_reg.last_row   <= last_row;
            s1_col_reg            <= col_reg;
            s1_row_reg            <= row_reg;
        end
    end

    always_comb begin
        s1_ctl       = s1_ctl_reg;
        s1_ctl.valid = s1_valid_reg;
    end

    assign s1_col    = s1_col_reg;
    assign s1_row    = s1_row_reg;
    // the above-row size arrives from the RAM while the cell sits in stage 1
    assign ram_re    = accept;
    assign ram_raddr = col_reg;

endmodule

/* hw/rtl/lesf_core.sv */
// Per-cell square size, best-square tracking and the result register.
// Depends on lesf_pkg for widths and the config and cell control structs.
module lesf_core #(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF,
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int SW      = $clog2(MAX_COLS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lesf_pkg::cfg_t                      cfg,
    input  lesf_pkg::cell_ctl_t                 s1_ctl,
    input  logic [CW-1:0]                       s1_col,
    input  logic [RW-1:0]                       s1_row,
    output logic                                s1_adv,
    input  logic [SW-1:0]                       ram_rdata,
    output logic                                ram_we,
    output logic [CW-1:0]                       ram_waddr,
    output logic [SW-1:0]                       ram_wdata,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_found,
    output logic [lesf_pkg::SIZE_OUT_W-1:0]     m_square_size,
    output logic [lesf_pkg::POS_OUT_W-1:0]      m_corner_row,
    output logic [lesf_pkg::POS_OUT_W-1:0]      m_corner_col
);

    logic [SW-1:0] left_reg, diag_reg, best_size_reg;
    logic [RW-1:0] best_row_reg;
    logic [CW-1:0] best_col_reg;
    logic          m_valid_reg;
    logic          m_found_reg;
    logic [lesf_pkg::SIZE_OUT_W-1:0] m_size_reg;
    logic [lesf_pkg::POS_OUT_W-1:0]  m_row_reg, m_col_reg;

    logic [SW-1:0] up, min_ul, min_all, size;
    logic [SW-1:0] best_size_next;
    logic [RW-1:0] best_row_next;
    logic [CW-1:0] best_col_next;
    logic          grid_end;

    assign up       = ram_rdata;
    assign grid_end = s1_ctl.last_col && s1_ctl.last_row;
    assign s1_adv   = s1_ctl.valid && (!grid_end || !m_valid_reg || m_ready);

    always_comb begin
        min_ul  = (up < left_reg) ? up : left_reg;
        min_all = (diag_reg < min_ul) ? diag_reg : min_ul;
        if (!s1_ctl.cell_empty) begin
            size = '0;
        end else if (s1_ctl.first_row || s1_ctl.first_col) begin
            size = SW'(1);
        end else begin
            size = min_all + SW'(1);
        end
    end

    // strictly larger only: the earliest cell in scan order keeps a tie
    always_comb begin
        best_size_next = best_size_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (size > best_size_reg) begin
            best_size_next = size;
            best_row_next  = s1_row;
            best_col_next  = s1_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end else if (cfg.restart) begin
            left_reg      <= '0;
            diag_reg      <= '0;
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end else if (s1_adv) begin
            if (s1_ctl.last_col) begin
                left_reg <= '0;
                diag_reg <= '0;
            end else begin
                left_reg <= size;
                diag_reg <= up;
            end
            if (grid_end) begin
                best_size_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end else begin
                best_size_reg <= best_size_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv && grid_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && grid_end) begin
            m_found_reg <= (best_size_next != '0);
            m_size_reg  <= lesf_pkg::SIZE_OUT_W'(best_size_next);
            m_row_reg   <= lesf_pkg::POS_OUT_W'(best_row_next);
            m_col_reg   <= lesf_pkg::POS_OUT_W'(best_col_next);
        end
    end

    assign ram_we    = s1_adv;
    assign ram_waddr = s1_col;
    assign ram_wdata = size;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_square_size = m_size_reg;
    assign m_corner_row  = m_row_reg;
    assign m_corner_col  = m_col_reg;

endmodule

/* hw/rtl/lesf_chk.sv */
// Port-level checker for the largest empty square finder, bound to the top level.
// Depends on lesf_pkg for port widths.
module lesf_chk (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_found,
    input logic [lesf_pkg::SIZE_OUT_W-1:0] m_square_size,
    input logic [lesf_pkg::POS_OUT_W-1:0]  m_corner_row,
    input logic [lesf_pkg::POS_OUT_W-1:0]  m_corner_col
);

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_square_size)
            && $stable(m_corner_row) && $stable(m_corner_col))
        else $error("result changed while stalled");

    a_found_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_found == (m_square_size != '0)))
        else $error("found flag disagrees with square size");

    a_empty_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> (m_corner_row == '0) && (m_corner_col == '0))
        else $error("corner reported for a grid with no empty cell");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind largest_empty_square_finder_core lesf_chk u_lesf_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_square_size (m_square_size),
    .m_corner_row  (m_corner_row),
    .m_corner_col  (m_corner_col)
);
